// ===== rtl/printable_run_extractor_macros.svh =====
// Assertion helpers for the printable run extractor.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef PRINTABLE_RUN_EXTRACTOR_MACROS_SVH
`define PRINTABLE_RUN_EXTRACTOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PRE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("printable_run_extractor: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PRE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("printable_run_extractor: next-cycle check failed");

`endif

// ===== rtl/pre_pkg.sv =====
package pre_pkg;

    localparam int MIN_W  = 5;
    localparam int CHAR_W = 8;
    localparam int OFF_W  = 32;

    localparam logic [CHAR_W-1:0] LF_CHAR    = 8'h0A;
    localparam logic [CHAR_W-1:0] TAB_CHAR   = 8'h09;
    localparam logic [CHAR_W-1:0] PRINT_LO   = 8'h20;
    localparam logic [CHAR_W-1:0] PRINT_HI   = 8'h7E;
    localparam logic [MIN_W-1:0]  MIN_LEN_RST = 5'd4;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_READ,
        S_SEND,
        S_EOL,
        S_STORE
    } t_state;

    // Buffer strobes from the sequencer
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_cmd;

    // Printable ASCII or tab
    function automatic logic is_printable(input logic [CHAR_W-1:0] c);
        return ((c >= PRINT_LO) && (c <= PRINT_HI)) || (c == TAB_CHAR);
    endfunction

endpackage

// ===== rtl/pre_ifs.sv =====
// Input channel: one file byte per transaction
interface pre_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

// Output channel: one string byte or line end per transaction
interface pre_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_char;
    logic        is_line_end;
    logic        starts_string;
    logic [31:0] start_offset;
    logic        last;

    modport source (output valid, output out_char, output is_line_end,
                    output starts_string, output start_offset, output last,
                    input ready);
    modport sink   (input valid, input out_char, input is_line_end,
                    input starts_string, input start_offset, input last,
                    output ready);
endinterface

// ===== rtl/printable_run_extractor.sv =====
// Channel   Dir  Payload
// i_in      in   data_byte[7:0], end_of_file
// o_out     out  out_char[7:0], is_line_end, starts_string, start_offset[31:0], last
// i_cfg_*   in   min_length[4:0], written when i_cfg_we is high
//
// A byte that flushes nothing is handled in idle. A flush runs a setup step, then a
// buffer read and an output load per buffered byte, a line-end step and a store step for
// a byte that follows a full-buffer flush; no new byte is taken until it returns to idle.
// A stalled output register holds the sequencer in its send states.
// Reset is synchronous, active low; the run buffer needs no clearing pass.
module printable_run_extractor #(
    parameter int BUF_BYTES = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [pre_pkg::MIN_W-1:0] i_cfg_data,
    pre_in_if.sink                    i_in,
    pre_out_if.source                 o_out
);
    import pre_pkg::*;

    localparam int CAP_MAX = (BUF_BYTES - 1 > 31) ? BUF_BYTES - 1 : 31;
    localparam int AW      = $clog2(CAP_MAX);

    logic [MIN_W-1:0]  r_min_len;
    t_mem_cmd          mem_cmd;
    logic [AW-1:0]     waddr, raddr;
    logic [CHAR_W-1:0] wdata, rdata;

    // Minimum length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= MIN_LEN_RST;
        end else if (i_cfg_we) begin
            r_min_len <= i_cfg_data;
        end
    end

    pre_seq #(
        .BUF_BYTES (BUF_BYTES),
        .AW        (AW)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_min_len (r_min_len),
        .i_in      (i_in),
        .o_out     (o_out),
        .o_mem_cmd (mem_cmd),
        .o_waddr   (waddr),
        .o_wdata   (wdata),
        .o_raddr   (raddr),
        .i_rdata   (rdata)
    );

    pre_buf #(
        .DEPTH (CAP_MAX),
        .AW    (AW)
    ) u_buf (
        .i_clk   (i_clk),
        .i_cmd   (mem_cmd),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule

// ===== rtl/pre_buf.sv =====
module pre_buf #(
    parameter int DEPTH = 31,
    parameter int AW    = 5
) (
    input  logic              i_clk,
    input  pre_pkg::t_mem_cmd i_cmd,
    input  logic [AW-1:0]     i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [7:0]        o_rdata
);
    import pre_pkg::*;

    logic [CHAR_W-1:0] r_mem [DEPTH];
    logic [CHAR_W-1:0] r_rdata;

    // Run buffer: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pre_seq.sv =====
`include "printable_run_extractor_macros.svh"

module pre_seq #(
    parameter int BUF_BYTES = 32,
    parameter int AW        = 5
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [pre_pkg::MIN_W-1:0] i_min_len,
    pre_in_if.sink                    i_in,
    pre_out_if.source                 o_out,
    output pre_pkg::t_mem_cmd         o_mem_cmd,
    output logic [AW-1:0]             o_waddr,
    output logic [7:0]                o_wdata,
    output logic [AW-1:0]             o_raddr,
    input  logic [7:0]                i_rdata
);
    import pre_pkg::*;

    localparam int CAP_MAX = (BUF_BYTES - 1 > 31) ? BUF_BYTES - 1 : 31;
    localparam int FW      = $clog2(CAP_MAX + 1);

    // Block state
    t_state          r_state, n_state;
    logic [FW-1:0]   r_fill, n_fill;
    logic            r_head, n_head;
    logic [OFF_W-1:0] r_offset, n_offset;

    // Per-transaction job registers
    logic [CHAR_W-1:0] r_byte, n_byte;
    logic            r_print, n_print;
    logic            r_do2, n_do2;
    logic            r_phase2, n_phase2;
    logic [FW-1:0]   r_cnt, n_cnt;
    logic [FW-1:0]   r_cnt2, n_cnt2;
    logic            r_head_e, n_head_e;
    logic            r_head2, n_head2;
    logic            r_eol, n_eol;
    logic [FW-1:0]   r_idx, n_idx;
    logic [OFF_W-1:0] r_start, n_start;
    logic [OFF_W-1:0] r_pos, n_pos;

    // Output register
    logic            r_o_valid, n_o_valid;
    logic [CHAR_W-1:0] r_o_char, n_o_char;
    logic            r_o_eol, n_o_eol;
    logic            r_o_st, n_o_st;
    logic [OFF_W-1:0] r_o_off, n_o_off;
    logic            r_o_last, n_o_last;

    // Accept-time decode
    logic [MIN_W-1:0] em;
    logic [FW-1:0]   em_w, thr, cap, fill_a, tt;
    logic            print, do1, do2, hp_a, accept;
    logic            out_free, final_emit, emit_done, load_em2, first_byte;

    assign em     = (i_min_len == '0) ? MIN_W'(1) : i_min_len;
    assign em_w   = FW'(em);
    assign thr    = r_head ? em_w : '0;
    assign cap    = (em_w > FW'(BUF_BYTES - 1)) ? em_w : FW'(BUF_BYTES - 1);
    assign print  = is_printable(i_in.data_byte);
    assign do1    = (!print && (r_fill >= thr)) || (r_fill >= cap);
    assign fill_a = do1 ? (print ? FW'(1) : '0) : (print ? r_fill + FW'(1) : '0);
    assign hp_a   = do1 ? !print : r_head;
    assign tt     = hp_a ? em_w : FW'(1);
    assign do2    = i_in.end_of_file && (fill_a >= tt);

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign out_free   = !r_o_valid || o_out.ready;
    assign final_emit = r_phase2 || !r_do2;
    assign first_byte = (r_idx == '0) && r_head_e;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_head    <= 1'b1;
            r_offset  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_fill    <= n_fill;
            r_head    <= n_head;
            r_offset  <= n_offset;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_byte   <= n_byte;
        r_print  <= n_print;
        r_do2    <= n_do2;
        r_phase2 <= n_phase2;
        r_cnt    <= n_cnt;
        r_cnt2   <= n_cnt2;
        r_head_e <= n_head_e;
        r_head2  <= n_head2;
        r_eol    <= n_eol;
        r_idx    <= n_idx;
        r_start  <= n_start;
        r_pos    <= n_pos;
        r_o_char <= n_o_char;
        r_o_eol  <= n_o_eol;
        r_o_st   <= n_o_st;
        r_o_off  <= n_o_off;
        r_o_last <= n_o_last;
    end

    // Sequencer: next state, job setup, buffer access, output load
    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_head    = r_head;
        n_offset  = r_offset;
        n_byte    = r_byte;
        n_print   = r_print;
        n_do2     = r_do2;
        n_phase2  = r_phase2;
        n_cnt     = r_cnt;
        n_cnt2    = r_cnt2;
        n_head_e  = r_head_e;
        n_head2   = r_head2;
        n_eol     = r_eol;
        n_idx     = r_idx;
        n_start   = r_start;
        n_pos     = r_pos;
        n_o_valid = r_o_valid && !o_out.ready;
        n_o_char  = r_o_char;
        n_o_eol   = r_o_eol;
        n_o_st    = r_o_st;
        n_o_off   = r_o_off;
        n_o_last  = r_o_last;
        o_mem_cmd = '0;
        o_waddr   = r_fill[AW-1:0];
        o_wdata   = i_in.data_byte;
        o_raddr   = r_idx[AW-1:0];
        emit_done = 1'b0;
        load_em2  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_byte   = i_in.data_byte;
                    n_print  = print;
                    n_do2    = do2;
                    n_cnt2   = fill_a;
                    n_head2  = hp_a;
                    n_pos    = r_offset;
                    n_phase2 = 1'b0;
                    n_cnt    = r_fill;
                    n_eol    = !print;
                    n_head_e = r_head;
                    // byte goes straight in when the buffer is not flushed first
                    o_mem_cmd.wr_en = print && !do1;
                    if (i_in.end_of_file) begin
                        n_fill   = '0;
                        n_head   = 1'b1;
                        n_offset = '0;
                    end else begin
                        n_fill   = fill_a;
                        n_head   = hp_a;
                        n_offset = r_offset + OFF_W'(1);
                    end
                    if (do1) begin
                        n_state = S_SETUP;
                    end else if (do2) begin
                        load_em2 = 1'b1;
                    end
                end
            end
            S_SETUP: begin
                // shared adder: start offset of the emitted run
                n_start = r_pos - OFF_W'(r_cnt) + OFF_W'(r_phase2);
                n_idx   = '0;
                n_state = (r_cnt == '0) ? S_EOL : S_READ;
            end
            S_READ: begin
                o_mem_cmd.rd_en = 1'b1;
                n_state = S_SEND;
            end
            S_SEND: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_char  = i_rdata;
                    n_o_eol   = 1'b0;
                    n_o_st    = first_byte;
                    n_o_off   = first_byte ? r_start : '0;
                    n_o_last  = (r_idx == r_cnt - FW'(1)) && !r_eol && final_emit;
                    n_idx     = r_idx + FW'(1);
                    if (r_idx == r_cnt - FW'(1)) begin
                        if (r_eol) begin
                            n_state = S_EOL;
                        end else begin
                            emit_done = 1'b1;
                        end
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_EOL: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_char  = LF_CHAR;
                    n_o_eol   = 1'b1;
                    n_o_st    = 1'b0;
                    n_o_off   = '0;
                    n_o_last  = final_emit;
                    emit_done = 1'b1;
                end
            end
            S_STORE: begin
                // byte that followed a full-buffer flush lands at the head
                o_mem_cmd.wr_en = 1'b1;
                o_waddr = '0;
                o_wdata = r_byte;
                if (r_do2) begin
                    load_em2 = 1'b1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // End of one emission: store pending byte, then trailing flush
        if (emit_done) begin
            if (r_phase2) begin
                n_state = S_IDLE;
            end else if (r_print) begin
                n_state = S_STORE;
            end else if (r_do2) begin
                load_em2 = 1'b1;
            end else begin
                n_state = S_IDLE;
            end
        end

        // Trailing flush at end of file
        if (load_em2) begin
            n_state  = S_SETUP;
            n_phase2 = 1'b1;
            n_cnt    = accept ? fill_a : r_cnt2;
            n_head_e = accept ? hp_a : r_head2;
            n_eol    = 1'b1;
        end
    end

    // Output channel
    assign o_out.valid         = r_o_valid;
    assign o_out.out_char      = r_o_char;
    assign o_out.is_line_end   = r_o_eol;
    assign o_out.starts_string = r_o_st;
    assign o_out.start_offset  = r_o_off;
    assign o_out.last          = r_o_last;

    // Checks
    `PRE_ASSERT_SAME(a_send_in_range, r_state == S_SEND, r_idx < r_cnt)
    `PRE_ASSERT_SAME(a_fill_bound, 1'b1, r_fill <= FW'(CAP_MAX))
    `PRE_ASSERT_NEXT(a_eof_clears, accept && i_in.end_of_file, (r_fill == '0) && r_head && (r_offset == '0))
    `PRE_ASSERT_SAME(a_head_not_eol, r_o_valid && r_o_st, !r_o_eol)

endmodule

// ===== tb/sv/printable_run_extractor_tb.sv =====
`timescale 1ns / 1ps

module printable_run_extractor_tb;
    import pre_pkg::*;

    localparam int BUF_BYTES      = 32;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 100;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 50;

    // One file byte as offered on the input channel
    typedef struct packed {
        logic [CHAR_W-1:0] data;
        logic              eof;
    } t_file_byte;

    // One emitted string byte or line end
    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              is_line_end;
        logic              starts_string;
        logic [OFF_W-1:0]  start_offset;
        logic              last;
    } t_string_char;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [MIN_W-1:0]  i_cfg_data;

    pre_in_if  in_ch();
    pre_out_if out_ch();

    printable_run_extractor #(
        .BUF_BYTES (BUF_BYTES)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #4 i_clk = ~i_clk;

    // Stimulus and expectation stores
    t_file_byte   file_bytes_q[$];
    t_string_char expected_chars_q[$];
    t_file_byte   cur_byte;
    int           queued_total = 0;
    int           in_acc_cnt   = 0;
    int           mismatch_cnt = 0;
    int           stall_cycles = 0;
    logic         in_fire;

    // Handshake shaping
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int hold_seq      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    // Shadow copy of the extractor state
    logic [CHAR_W-1:0] run_buf[0:63];
    int                fill_cnt  = 0;
    logic              head_pend = 1'b1;
    logic [OFF_W-1:0]  byte_offs = '0;
    logic [MIN_W-1:0]  min_len   = MIN_LEN_RST;

    function automatic logic printable(input logic [CHAR_W-1:0] c);
        return (c == TAB_CHAR) || ((c >= PRINT_LO) && (c <= PRINT_HI));
    endfunction

    // Push the buffered run; pos is the offset just past its last byte
    function automatic void flush_run(input logic [OFF_W-1:0] pos, input logic line_end);
        t_string_char     r;
        logic [OFF_W-1:0] start;
        start = pos - OFF_W'(fill_cnt);
        for (int i = 0; i < fill_cnt; i++) begin
            r.out_char      = run_buf[i];
            r.is_line_end   = 1'b0;
            r.starts_string = (i == 0) && head_pend;
            r.start_offset  = r.starts_string ? start : '0;
            r.last          = 1'b0;
            expected_chars_q.push_back(r);
        end
        if (line_end) begin
            r.out_char      = LF_CHAR;
            r.is_line_end   = 1'b1;
            r.starts_string = 1'b0;
            r.start_offset  = '0;
            r.last          = 1'b0;
            expected_chars_q.push_back(r);
        end
    endfunction

    // Advance the shadow state by one file byte and queue what it emits
    function automatic void scan_byte(input logic [CHAR_W-1:0] c, input logic eof);
        int   eff;
        int   thr;
        int   cap;
        int   tail_thr;
        int   n0;
        logic prn;
        n0  = expected_chars_q.size();
        eff = (min_len == 0) ? 1 : int'(min_len);
        thr = head_pend ? eff : 0;
        cap = (eff > BUF_BYTES - 1) ? eff : BUF_BYTES - 1;
        prn = printable(c);
        // terminator on a long enough run, or a full buffer
        if ((!prn && fill_cnt >= thr) || fill_cnt >= cap) begin
            flush_run(byte_offs, !prn);
            fill_cnt  = 0;
            head_pend = !prn;
        end
        if (prn) begin
            run_buf[fill_cnt] = c;
            fill_cnt++;
        end else begin
            fill_cnt = 0;
        end
        byte_offs++;
        // trailing run at end of file, continuation needs one byte
        if (eof) begin
            tail_thr = head_pend ? eff : 1;
            if (fill_cnt >= tail_thr)
                flush_run(byte_offs, 1'b1);
            fill_cnt  = 0;
            head_pend = 1'b1;
            byte_offs = '0;
        end
        if (expected_chars_q.size() > n0)
            expected_chars_q[expected_chars_q.size() - 1].last = 1'b1;
    endfunction

    // Input driver: new item only when the previous one was taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_fire) begin
            if (file_bytes_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                cur_byte = file_bytes_q.pop_front();
                in_ch.valid       <= 1'b1;
                in_ch.data_byte   <= cur_byte.data;
                in_ch.end_of_file <= cur_byte.eof;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Output ready: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_seq != hold_seen) begin
            hold_seen    <= hold_seq;
            hold_left    <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Monitor: predict on input transactions, check output transactions
    always @(posedge i_clk) begin
        t_string_char exp_c;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready) begin
                scan_byte(in_ch.data_byte, in_ch.end_of_file);
                in_acc_cnt <= in_acc_cnt + 1;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (expected_chars_q.size() == 0) begin
                    if (mismatch_cnt < 10)
                        $display("%0t: unexpected result char=%h eol=%b st=%b off=%h last=%b",
                                 $realtime, out_ch.out_char, out_ch.is_line_end,
                                 out_ch.starts_string, out_ch.start_offset, out_ch.last);
                    mismatch_cnt++;
                end else begin
                    exp_c = expected_chars_q.pop_front();
                    if (out_ch.out_char !== exp_c.out_char
                        || out_ch.is_line_end !== exp_c.is_line_end
                        || out_ch.starts_string !== exp_c.starts_string
                        || out_ch.start_offset !== exp_c.start_offset
                        || out_ch.last !== exp_c.last) begin
                        if (mismatch_cnt < 10)
                            $display({"%0t: exp char=%h eol=%b st=%b off=%h last=%b",
                                      " got char=%h eol=%b st=%b off=%h last=%b"},
                                     $realtime, exp_c.out_char, exp_c.is_line_end,
                                     exp_c.starts_string, exp_c.start_offset, exp_c.last,
                                     out_ch.out_char, out_ch.is_line_end,
                                     out_ch.starts_string, out_ch.start_offset, out_ch.last);
                        mismatch_cnt++;
                    end
                end
            end
        end
    end

    // Watchdog: cycles without any transaction while work is pending
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else if (in_acc_cnt != queued_total || expected_chars_q.size() != 0) begin
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("printable_run_extractor: mismatch");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    function automatic logic [CHAR_W-1:0] printable_char();
        int r;
        r = $urandom_range(95);
        return (r == 95) ? TAB_CHAR : PRINT_LO + CHAR_W'(r);
    endfunction

    function automatic logic [CHAR_W-1:0] control_char();
        logic [CHAR_W-1:0] v;
        v = CHAR_W'($urandom_range(255));
        while (printable(v))
            v = CHAR_W'($urandom_range(255));
        return v;
    endfunction

    function automatic void queue_byte(input logic [CHAR_W-1:0] c, input logic eof);
        t_file_byte b;
        b.data = c;
        b.eof  = eof;
        file_bytes_q.push_back(b);
        queued_total++;
    endfunction

    function automatic void queue_text(input string s, input logic eof_last);
        for (int i = 0; i < s.len(); i++)
            queue_byte(CHAR_W'(s[i]), eof_last && (i == s.len() - 1));
    endfunction

    // One file: mostly printable runs with separators, some noise
    function automatic void queue_file(input int n_items);
        t_file_byte fb[$];
        t_file_byte b;
        int         len;
        int         eff;
        eff = (min_len == 0) ? 1 : int'(min_len);
        b.eof = 1'b0;
        while (fb.size() < n_items) begin
            if ($urandom_range(99) < 15) begin
                b.data = CHAR_W'($urandom_range(255));
                fb.push_back(b);
            end else begin
                len = ($urandom_range(4) == 0) ? $urandom_range(28, 70)
                                               : $urandom_range(0, eff + 3);
                for (int i = 0; i < len; i++) begin
                    b.data = printable_char();
                    fb.push_back(b);
                end
                b.data = control_char();
                fb.push_back(b);
            end
        end
        while (fb.size() > n_items)
            void'(fb.pop_back());
        fb[fb.size() - 1].eof = 1'b1;
        foreach (fb[i])
            queue_byte(fb[i].data, fb[i].eof);
    endfunction

    task automatic queue_files(input int total);
        int n;
        n = 0;
        @(posedge i_clk);
        while (n < total) begin
            queue_file($urandom_range(8, 50) + (($urandom_range(9) == 0) ? 60 : 0));
            n = queued_total - in_acc_cnt;
        end
    endtask

    // Wait until every item is taken and every result has come out
    task automatic wait_idle();
        while (in_acc_cnt != queued_total || expected_chars_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic start_phase(input logic [MIN_W-1:0] m, input int src_pct, input int snk_pct);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        min_len = m;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_data        = '0;
        in_ch.valid       = 1'b0;
        in_ch.data_byte   = '0;
        in_ch.end_of_file = 1'b0;
        out_ch.ready      = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset minimum of four, no idling
        @(posedge i_clk);
        queue_text("a", 1'b0);
        queue_byte(8'h00, 1'b0);                // short run dropped
        queue_byte(TAB_CHAR, 1'b0);
        queue_byte(PRINT_LO, 1'b0);
        queue_byte(PRINT_HI, 1'b0);
        queue_text("H", 1'b0);
        queue_byte(8'h7F, 1'b0);                // run of exactly the minimum
        queue_byte(8'hFF, 1'b0);                // lone non-printable
        queue_text("wxyz", 1'b0);
        queue_byte(LF_CHAR, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_text("qrs", 1'b1);                // short trailing run at end of file
        queue_text("ABCD", 1'b1);               // trailing run flushed at end of file
        queue_text("ZZZZ", 1'b0);
        queue_byte(8'h1F, 1'b1);                // end of file on the terminator

        // Random phases across minimum settings and idling profiles
        start_phase(5'd1, 0, 0);
        queue_files(PHASE_ITEMS);
        start_phase(5'd31, 87, 0);
        queue_files(PHASE_ITEMS);
        start_phase(5'd0, 0, 87);
        queue_files(PHASE_ITEMS / 2);
        wait_idle();                            // sender waits for all results
        queue_files(PHASE_ITEMS / 2);
        start_phase(MIN_W'($urandom_range(2, 30)), 6, 6);
        queue_files(PHASE_ITEMS);
        start_phase(MIN_W'($urandom_range(1, 31)), 0, 0);
        queue_files(PHASE_ITEMS);

        // Long receiver hold-off while the sender keeps offering
        start_phase(MIN_W'($urandom_range(1, 8)), 0, 0);
        queue_files(PHASE_ITEMS);
        hold_seq++;

        wait_idle();
        if (expected_chars_q.size() != 0) begin
            $display("%0d expected results never arrived", expected_chars_q.size());
            mismatch_cnt += expected_chars_q.size();
        end
        if (mismatch_cnt == 0) begin
            $display("printable_run_extractor: match");
        end else begin
            $display("printable_run_extractor: mismatch");
        end
        $finish;
    end

endmodule
